@@ hdl/blhm_pkg.sv @@
// ----------------------------------------------------------------------------
// blhm_pkg
// Shared types and constants for the battery level hysteresis monitor.
// ----------------------------------------------------------------------------
package blhm_pkg;

   localparam int AVG_DEPTH = 16;
   localparam int PTR_W     = $clog2(AVG_DEPTH);
   localparam int SAMPLE_W  = 12;
   localparam int SUM_W     = SAMPLE_W + PTR_W;
   localparam int MARGIN_W  = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] KIND_SAMPLE  = 2'd0;
   localparam logic [1:0] KIND_MEASURE = 2'd1;
   localparam logic [1:0] KIND_BLINK   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_THR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN    = 2'd3;

   localparam logic [SAMPLE_W-1:0] HALF_THR_RST  = 12'd2900;
   localparam logic [SAMPLE_W-1:0] EMPTY_THR_RST = 12'd2700;
   localparam logic [SAMPLE_W-1:0] ZERO_THR_RST  = 12'd2500;
   localparam logic [MARGIN_W-1:0] MARGIN_RST    = 8'd20;

   typedef enum logic [2:0] {
      LVL_CHARGING = 3'd0,
      LVL_FULL     = 3'd1,
      LVL_HALF     = 3'd2,
      LVL_EMPTY    = 3'd3,
      LVL_ZERO     = 3'd4
   } level_type;

   localparam logic [2:0] ICON_EMPTY   = 3'd3;
   localparam logic [2:0] ICON_NOTHING = 3'd4;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SAMPLE_W-1:0] sample;
      logic                charging;
   } req_type;

   typedef struct packed {
      logic [2:0]          level;
      logic [2:0]          icon;
      logic [SAMPLE_W-1:0] mean;
   } rsp_type;

endpackage

@@ hdl/blhm_ram.sv @@
// ----------------------------------------------------------------------------
// blhm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module blhm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/battery_level_hysteresis_monitor_core.sv @@
// ----------------------------------------------------------------------------
// battery_level_hysteresis_monitor_core
// Moving-average battery gauge: sample ring in RAM, running sum, five-level
// hysteresis state and blinking zero icon.
// ----------------------------------------------------------------------------
// Path: req beat to stage 1 (ring RAM read), then update to rsp register.
// Throughput: one beat per cycle unless rsp_ready stalls the pipeline.
// Reset: synchronous; ring reads as zero through per-entry valid flops, so
// no clearing pass is needed and req is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module battery_level_hysteresis_monitor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  blhm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output blhm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [blhm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [blhm_pkg::SAMPLE_W-1:0]       csr_wdata
);

   localparam int SW = blhm_pkg::SAMPLE_W;
   localparam int PW = blhm_pkg::PTR_W;
   localparam int UW = blhm_pkg::SUM_W;

   logic [SW-1:0]                 half_thr_ff, empty_thr_ff, zero_thr_ff;
   logic [blhm_pkg::MARGIN_W-1:0] margin_ff;

   logic [PW-1:0]                 ptr_ff, ptr_in;
   logic                          s1_valid_ff;
   blhm_pkg::req_type             s1_item_ff;
   logic [PW-1:0]                 s1_ptr_ff;
   logic                          rsp_valid_ff;
   blhm_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [UW-1:0]                 sum_ff, sum_in;
   blhm_pkg::level_type           level_ff, level_in;
   logic                          blink_ff, blink_in;
   logic [2:0]                    icon_ff, icon_in;
   logic [blhm_pkg::AVG_DEPTH-1:0] ring_vld_ff;

   logic                          req_acc, s1_adv, is_sample, wr_en;
   logic [SW-1:0]                 ram_rdata, old_sample, mean_cur;
   logic [SW:0]                   rise_half, rise_empty, rise_zero, mean_x;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         half_thr_ff  <= blhm_pkg::HALF_THR_RST;
         empty_thr_ff <= blhm_pkg::EMPTY_THR_RST;
         zero_thr_ff  <= blhm_pkg::ZERO_THR_RST;
         margin_ff    <= blhm_pkg::MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            blhm_pkg::CSR_HALF_THR:  half_thr_ff  <= csr_wdata;
            blhm_pkg::CSR_EMPTY_THR: empty_thr_ff <= csr_wdata;
            blhm_pkg::CSR_ZERO_THR:  zero_thr_ff  <= csr_wdata;
            blhm_pkg::CSR_MARGIN:    margin_ff    <= csr_wdata[blhm_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake ----------------
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ptr_in = (req_acc && req_data.kind == blhm_pkg::KIND_SAMPLE)
                   ? ptr_ff + PW'(1) : ptr_ff;

   // ---------------- ring memory ----------------
   assign is_sample = s1_item_ff.kind == blhm_pkg::KIND_SAMPLE;
   assign wr_en     = s1_adv && is_sample;

   blhm_ram #(
      .WIDTH (SW),
      .DEPTH (blhm_pkg::AVG_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_ptr_ff),
      .wr_data (s1_item_ff.sample),
      .rd_en   (req_acc),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   assign old_sample = ring_vld_ff[s1_ptr_ff] ? ram_rdata : '0;

   // ---------------- update ----------------
   assign mean_cur   = sum_ff[PW +: SW];
   assign mean_x     = {1'b0, mean_cur};
   assign rise_half  = {1'b0, half_thr_ff}  + (SW+1)'(margin_ff);
   assign rise_empty = {1'b0, empty_thr_ff} + (SW+1)'(margin_ff);
   assign rise_zero  = {1'b0, zero_thr_ff}  + (SW+1)'(margin_ff);

   always_comb begin
      sum_in   = sum_ff;
      level_in = level_ff;
      blink_in = blink_ff;
      icon_in  = icon_ff;
      case (s1_item_ff.kind)
         blhm_pkg::KIND_SAMPLE: begin
            sum_in = sum_ff - UW'(old_sample) + UW'(s1_item_ff.sample);
         end
         blhm_pkg::KIND_MEASURE: begin
            if (s1_item_ff.charging) begin
               level_in = blhm_pkg::LVL_CHARGING;
            end else if (level_ff == blhm_pkg::LVL_FULL && mean_cur < half_thr_ff) begin
               level_in = blhm_pkg::LVL_HALF;
            end else if (level_ff == blhm_pkg::LVL_HALF && mean_cur < empty_thr_ff) begin
               level_in = blhm_pkg::LVL_EMPTY;
            end else if (level_ff == blhm_pkg::LVL_EMPTY && mean_cur < zero_thr_ff) begin
               level_in = blhm_pkg::LVL_ZERO;
            end else if (level_ff == blhm_pkg::LVL_ZERO && mean_x > rise_zero) begin
               level_in = blhm_pkg::LVL_EMPTY;
            end else if (level_ff == blhm_pkg::LVL_EMPTY && mean_x > rise_empty) begin
               level_in = blhm_pkg::LVL_HALF;
            end else if (level_ff == blhm_pkg::LVL_HALF && mean_x > rise_half) begin
               level_in = blhm_pkg::LVL_FULL;
            end else if (level_ff == blhm_pkg::LVL_CHARGING) begin
               level_in = blhm_pkg::LVL_ZERO;
            end
         end
         blhm_pkg::KIND_BLINK: begin
            if (level_ff == blhm_pkg::LVL_ZERO) begin
               icon_in  = blink_ff ? blhm_pkg::ICON_EMPTY : blhm_pkg::ICON_NOTHING;
               blink_in = !blink_ff;
            end else begin
               icon_in = level_ff;
            end
         end
         default: ;
      endcase
      rsp_data_in.level = level_in;
      rsp_data_in.icon  = icon_in;
      rsp_data_in.mean  = sum_in[PW +: SW];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         level_ff     <= blhm_pkg::LVL_FULL;
         blink_ff     <= 1'b0;
         icon_ff      <= blhm_pkg::LVL_FULL;
         ring_vld_ff  <= '0;
      end else begin
         ptr_ff <= ptr_in;
         if (req_ready) begin
            s1_valid_ff <= req_acc;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= sum_in;
            level_ff     <= level_in;
            blink_ff     <= blink_in;
            icon_ff      <= icon_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            ring_vld_ff[s1_ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_item_ff <= req_data;
         s1_ptr_ff  <= ptr_ff;
      end
      if (s1_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ---------------- assertions ----------------
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_item_ff))
      else $error("stage 1 item dropped while stalled");

   a_charge: assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_item_ff.kind == blhm_pkg::KIND_MEASURE && s1_item_ff.charging
      |=> level_ff == blhm_pkg::LVL_CHARGING)
      else $error("charging measure did not set charging level");

   a_blink_stable: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && s1_item_ff.kind == blhm_pkg::KIND_BLINK &&
        level_ff == blhm_pkg::LVL_ZERO) |=> $stable(blink_ff))
      else $error("blink phase changed outside a zero-level blink beat");

   a_sum_state: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(sum_ff) && $stable(level_ff))
      else $error("state changed without a committed beat");

   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_data.kind != blhm_pkg::KIND_SAMPLE |=> $stable(ptr_ff))
      else $error("ring pointer moved on a tick beat");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery level hysteresis monitor. A shadow
// gauge (sample ring, running sum, five-level hysteresis state, blinking
// icon) predicts every rsp beat from each accepted req beat; rsp beats are
// checked field by field in order. Directed cases come first, then sample
// bursts mostly aimed at thresholds under several register settings and
// idle/stall patterns, a long rsp hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_top;
   import blhm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } pace_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]  csr_wdata = '0;

   battery_level_hysteresis_monitor_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers and gauge state
   logic [SAMPLE_W-1:0] thr_half   = HALF_THR_RST;
   logic [SAMPLE_W-1:0] thr_empty  = EMPTY_THR_RST;
   logic [SAMPLE_W-1:0] thr_zero   = ZERO_THR_RST;
   logic [MARGIN_W-1:0] thr_margin = MARGIN_RST;

   logic [SAMPLE_W-1:0] ring_mem [AVG_DEPTH];
   logic [PTR_W-1:0]    ring_wr_ptr = '0;
   logic [SUM_W-1:0]    ring_sum = '0;
   level_type           gauge_level = LVL_FULL;
   logic                blink_phase = 1'b0;
   logic [2:0]          gauge_icon = LVL_FULL;

   rsp_type  expected_q[$];
   pace_type pace = IDLE_NONE;
   int       beats_sent = 0;
   int       mismatch_count = 0;
   int       cycle_count = 0;
   int       rsp_hold_request = 0;
   int       rsp_hold_left = 0;

   initial begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
   end

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic rsp_type step_gauge(input req_type beat);
      rsp_type                 res;
      logic [SAMPLE_W-1:0]     avg;
      level_type               lvl;
      avg = ring_sum[SUM_W-1:PTR_W];
      case (beat.kind)
         KIND_SAMPLE: begin
            ring_sum = ring_sum - ring_mem[ring_wr_ptr] + beat.sample;
            ring_mem[ring_wr_ptr] = beat.sample;
            ring_wr_ptr = ring_wr_ptr + 1'b1;
         end
         KIND_MEASURE: begin
            lvl = gauge_level;
            if (beat.charging) lvl = LVL_CHARGING;
            else if (lvl == LVL_FULL && avg < thr_half) lvl = LVL_HALF;
            else if (lvl == LVL_HALF && avg < thr_empty) lvl = LVL_EMPTY;
            else if (lvl == LVL_EMPTY && avg < thr_zero) lvl = LVL_ZERO;
            else if (lvl == LVL_ZERO && avg > 13'(thr_zero) + thr_margin) lvl = LVL_EMPTY;
            else if (lvl == LVL_EMPTY && avg > 13'(thr_empty) + thr_margin) lvl = LVL_HALF;
            else if (lvl == LVL_HALF && avg > 13'(thr_half) + thr_margin) lvl = LVL_FULL;
            else if (lvl == LVL_CHARGING) lvl = LVL_ZERO;
            gauge_level = lvl;
         end
         KIND_BLINK: begin
            if (gauge_level == LVL_ZERO) begin
               gauge_icon  = blink_phase ? ICON_EMPTY : ICON_NOTHING;
               blink_phase = ~blink_phase;
            end else begin
               gauge_icon = gauge_level;
            end
         end
         default: ;
      endcase
      res.level = gauge_level;
      res.icon  = gauge_icon;
      res.mean  = ring_sum[SUM_W-1:PTR_W];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // register writes, req acceptance and rsp checking, all on the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_THR:  thr_half   = csr_wdata;
               CSR_EMPTY_THR: thr_empty  = csr_wdata;
               CSR_ZERO_THR:  thr_zero   = csr_wdata;
               CSR_MARGIN:    thr_margin = csr_wdata[MARGIN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_q.push_back(step_gauge(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat level=%0d icon=%0d mean=%0d",
                                         rsp_data.level, rsp_data.icon, rsp_data.mean));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.level !== want.level)
                  report_mismatch($sformatf("level %0d, want %0d", rsp_data.level, want.level));
               if (rsp_data.icon !== want.icon)
                  report_mismatch($sformatf("icon %0d, want %0d", rsp_data.icon, want.icon));
               if (rsp_data.mean !== want.mean)
                  report_mismatch($sformatf("mean %0d, want %0d", rsp_data.mean, want.mean));
            end
         end
      end
   end

   // rsp side: random stalls per pace, plus a counted hold-off on request
   always @(negedge clock) begin : receiver
      int stall_pct;
      stall_pct = (pace == IDLE_RECEIVER) ? 71 : (pace == IDLE_BOTH) ? 17 : 0;
      if (rsp_hold_request > 0) begin
         rsp_hold_left    = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= int'($urandom_range(0, 99)) >= stall_pct;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_beat(input req_type beat);
      int idle_pct;
      idle_pct = (pace == IDLE_SENDER) ? 71 : (pace == IDLE_BOTH) ? 17 : 0;
      @(negedge clock);
      while (int'($urandom_range(0, 99)) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   task automatic send_item(input logic [1:0] kind, input int sample, input bit charging);
      req_type beat;
      beat.kind     = kind;
      beat.sample   = sample[SAMPLE_W-1:0];
      beat.charging = charging;
      send_beat(beat);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[SAMPLE_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_thresholds(input int half, input int empty, input int zero,
                                 input int margin);
      wait_drained();
      write_reg(CSR_HALF_THR, half);
      write_reg(CSR_EMPTY_THR, empty);
      write_reg(CSR_ZERO_THR, zero);
      write_reg(CSR_MARGIN, margin);
   endtask

   function automatic int clamp_sample(input int v);
      return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
   endfunction

   // samples around one threshold or a random level, then a measure tick, some blinks, some noise
   task automatic send_gauge_burst();
      int target;
      int n;
      req_type beat;
      case ($urandom_range(0, 3))
         0: target = int'(thr_half);
         1: target = int'(thr_empty);
         2: target = int'(thr_zero);
         default: target = $urandom_range(0, 4095);
      endcase
      target = target + int'($urandom_range(0, int'(thr_margin) + 80)) - 40;
      n = $urandom_range(1, 20);
      repeat (n) begin
         beat.kind     = KIND_SAMPLE;
         beat.charging = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) beat.sample = SAMPLE_W'($urandom_range(0, 4095));
         else beat.sample = SAMPLE_W'(clamp_sample(target + int'($urandom_range(0, 30)) - 15));
         send_beat(beat);
      end
      send_item(KIND_MEASURE, $urandom_range(0, 4095), $urandom_range(0, 11) == 0);
      repeat ($urandom_range(0, 3))
         send_item(KIND_BLINK, $urandom_range(0, 4095), $urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         beat.kind     = 2'($urandom_range(0, 3));
         beat.sample   = SAMPLE_W'($urandom_range(0, 4095));
         beat.charging = 1'($urandom_range(0, 1));
         send_beat(beat);
      end
   endtask

   task automatic run_traffic(input int count);
      int goal;
      pace_type p;
      p = IDLE_NONE;
      repeat (4) begin
         pace = p;
         goal = beats_sent + count / 4;
         while (beats_sent < goal) send_gauge_burst();
         p = p.next();
      end
      pace = IDLE_NONE;
   endtask

   task automatic test_directed();
      pace = IDLE_NONE;
      send_item(KIND_BLINK, 0, 1'b0);
      send_item(KIND_MEASURE, 4095, 1'b0);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_MEASURE, 4095, 1'b0);
      send_item(KIND_BLINK, 4095, 1'b1);
      send_item(KIND_BLINK, 0, 1'b0);
      send_item(KIND_BLINK, 0, 1'b1);
      send_item(KIND_MEASURE, 0, 1'b1);
      send_item(KIND_BLINK, 0, 1'b0);
      send_item(KIND_UNUSED, 4095, 1'b1);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_SAMPLE, 4095, 1'b1);
      send_item(KIND_SAMPLE, 4095, 1'b0);
      send_item(KIND_SAMPLE, 0, 1'b1);
      send_item(KIND_SAMPLE, 4095, 1'b0);
      send_item(KIND_MEASURE, 0, 1'b0);
      // low thresholds so the level climbs zero -> empty -> half -> full
      set_thresholds(600, 500, 400, 0);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_MEASURE, 0, 1'b0);
      send_item(KIND_BLINK, 0, 1'b0);
   endtask

   task automatic test_default_thresholds();
      set_thresholds(HALF_THR_RST, EMPTY_THR_RST, ZERO_THR_RST, MARGIN_RST);
      run_traffic(120);
   endtask

   task automatic test_threshold_extremes();
      set_thresholds(0, 0, 0, 0);
      run_traffic(60);
      // rise target beyond 4095: levels can only fall, apart from entering charging
      set_thresholds(4095, 4095, 4095, 255);
      run_traffic(60);
      set_thresholds(4095, 2048, 0, 255);
      run_traffic(32);
   endtask

   task automatic test_random_thresholds();
      int z;
      int e;
      repeat (2) begin
         z = $urandom_range(200, 3000);
         e = z + int'($urandom_range(50, 500));
         set_thresholds(e + int'($urandom_range(50, 500)), e, z, $urandom_range(0, 255));
         run_traffic(80);
      end
      set_thresholds($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 255));
      run_traffic(40);
   endtask

   task automatic test_backpressure();
      int goal;
      wait_drained();
      pace = IDLE_NONE;
      rsp_hold_request = 300;
      goal = beats_sent + 60;
      while (beats_sent < goal) send_gauge_burst();
   endtask

   task automatic test_drain_pause();
      int goal;
      pace = IDLE_BOTH;
      goal = beats_sent + 32;
      while (beats_sent < goal) send_gauge_burst();
      wait_drained();
      goal = beats_sent + 32;
      while (beats_sent < goal) send_gauge_burst();
      pace = IDLE_NONE;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_default_thresholds();
      test_threshold_extremes();
      test_random_thresholds();
      test_backpressure();
      test_drain_pause();
      wait_drained();
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", expected_q.size()));
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
